[sv/delimiter_string_splitter_macros.svh]
// ----------------------------------------------------------------------------
// Delimiter string splitter assertion macros
// Clocked assertion wrappers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_STRING_SPLITTER_MACROS_SVH
`define DELIMITER_STRING_SPLITTER_MACROS_SVH

// check prop at every edge outside reset
`define DSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every edge, reset included
`define DSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dss_pkg.sv]
// ----------------------------------------------------------------------------
// Delimiter string splitter package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int BYTE_W     = 8;
    localparam int PART_W     = 25;
    localparam int DLEN_W     = 4;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int BSM_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_LIMIT   = 2'd2;

    localparam logic [CFG_W-1:0]  RST_DELIM_BYTES  = 64'd44;
    localparam logic [DLEN_W-1:0] RST_DELIM_LENGTH = 4'd1;
    localparam logic [PART_W-1:0] RST_PART_LIMIT   = 25'd16777217;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [PART_W-1:0] part_index;
        logic [PART_W-1:0] part_start;
        logic [PART_W-1:0] part_length;
        logic              last_part;
        logic              empty_delimiter;
    } t_result;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

endpackage

[sv/dss_cell.sv]
// ----------------------------------------------------------------------------
// Delimiter string splitter window cell
// Holds one byte of the window, passes it on and compares its incoming byte.
// ----------------------------------------------------------------------------
module dss_cell
    import dss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic [BYTE_W-1:0] i_want,
    input  logic              i_care,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_hit
);

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte_in;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_care || (i_byte_in == i_want);

endmodule

[sv/dss_result_fifo.sv]
// ----------------------------------------------------------------------------
// Delimiter string splitter result queue
// Four-entry queue taking up to two results per cycle, giving one when not stalled.
// ----------------------------------------------------------------------------
`include "delimiter_string_splitter_macros.svh"

module dss_result_fifo
    import dss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_data0,
    input  t_result i_data1,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_room
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wp;
    logic [FIFO_PTR_W-1:0]  n_wp;
    logic [FIFO_PTR_W-1:0]  r_rp;
    logic [FIFO_PTR_W-1:0]  n_rp;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_CNT_W-1:0]  n_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_wp    = r_wp + FIFO_PTR_W'(i_push.push0) + FIFO_PTR_W'(i_push.push1);
        n_rp    = r_rp + FIFO_PTR_W'(w_pop);
        n_count = r_count + FIFO_CNT_W'(i_push.push0) + FIFO_CNT_W'(i_push.push1)
                  - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push.push1) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    `DSS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
    `DSS_ASSERT(a_push_order, i_clk, i_rst_n, i_push.push1 |-> i_push.push0, "second result without first")
    `DSS_ASSERT(a_push_room, i_clk, i_rst_n, i_push.push0 |-> r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2), "push without room")
    `DSS_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_wp - r_rp) == r_count[FIFO_PTR_W-1:0], "pointers disagree with count")

endmodule

[sv/delimiter_string_splitter.sv]
// ----------------------------------------------------------------------------
// Delimiter string splitter
// Splits a byte stream at a configured delimiter and reports each part.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_data_byte, i_has_byte, i_last_byte
//  result    out        o_valid / i_stall    o_part_index, o_part_start,
//                                            o_part_length, o_last_part,
//                                            o_empty_delimiter
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
//  One item per cycle unless stalled; a match is found in the cycle its last
//  byte is taken by the cell row compare; its result is written to the queue.
//  An item ending a string on a match gives two results through the queue.
//  Input stalls while fewer than two queue entries are free.
//  Synchronous active-low reset restores register defaults and empties the
//  queue; no clearing pass.
// ----------------------------------------------------------------------------
module delimiter_string_splitter
    import dss_pkg::*;
#(
    parameter int              MAX_DELIM_BYTES  = 8,
    parameter longint unsigned MAX_STRING_BYTES = 64'd16777216
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_has_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PART_W-1:0]    o_part_index,
    output logic [PART_W-1:0]    o_part_start,
    output logic [PART_W-1:0]    o_part_length,
    output logic                 o_last_part,
    output logic                 o_empty_delimiter,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_STRING_BYTES + 1);
    localparam int CMP_W = ((CNT_W > PART_W) ? CNT_W : PART_W) + 1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_STRING_BYTES);
    localparam logic [DLEN_W-1:0] DLEN_MAX = DLEN_W'(MAX_DELIM_BYTES);

    logic [CFG_W-1:0]  r_delim;
    logic [DLEN_W-1:0] r_dlen_cfg;
    logic [PART_W-1:0] r_limit;

    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_cps;
    logic [BSM_W-1:0]  r_bsm;
    logic [CNT_W-1:0]  r_parts;

    logic [CNT_W-1:0]  n_pos;
    logic [CNT_W-1:0]  n_cps;
    logic [BSM_W-1:0]  n_bsm;
    logic [CNT_W-1:0]  n_parts;

    logic              w_accept;
    logic              w_shift;
    logic              w_room;
    logic [DLEN_W-1:0] w_dlen;
    logic [PART_W-1:0] w_lim;
    logic [BYTE_W-1:0] w_byte [MAX_DELIM_BYTES];
    logic [MAX_DELIM_BYTES-1:0] w_hit;

    logic [CNT_W-1:0]  w_pos_inc;
    logic [BSM_W-1:0]  w_bsm_inc;
    logic [CNT_W-1:0]  w_parts_inc;
    logic              w_parts_ok;
    logic              w_match;
    logic [CNT_W:0]    w_p1;
    logic [CNT_W:0]    w_mstart;
    logic [CNT_W:0]    w_mlen;
    logic [CNT_W-1:0]  w_pos_a;
    logic [CNT_W-1:0]  w_cps_a;
    logic [CNT_W-1:0]  w_parts_a;
    logic [CNT_W-1:0]  w_flen;

    t_result           w_match_res;
    t_result           w_final_res;
    t_result           w_data0;
    t_result           w_out;
    t_push             w_push;

    assign w_accept = i_valid && !o_stall;
    assign w_shift  = w_accept && i_has_byte;
    assign o_stall  = !w_room;
    assign w_dlen   = (r_dlen_cfg > DLEN_MAX) ? DLEN_MAX : r_dlen_cfg;
    assign w_lim    = (r_limit == '0) ? PART_W'(1) : r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= RST_DELIM_BYTES;
            r_dlen_cfg <= RST_DELIM_LENGTH;
            r_limit    <= RST_PART_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIM_BYTES: begin
                    r_delim <= i_cfg_data;
                end
                CFG_DELIM_LENGTH: begin
                    r_dlen_cfg <= i_cfg_data[DLEN_W-1:0];
                end
                CFG_PART_LIMIT: begin
                    r_limit <= i_cfg_data[PART_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < MAX_DELIM_BYTES; k++) begin : g_cell
        logic [BYTE_W-1:0] w_in;
        logic [DLEN_W-1:0] w_sel;
        logic [BYTE_W-1:0] w_want;
        logic              w_care;

        if (k == 0) begin : g_head
            assign w_in = i_data_byte;
        end else begin : g_link
            assign w_in = w_byte[k-1];
        end

        assign w_sel  = w_dlen - DLEN_W'(k) - DLEN_W'(1);
        assign w_want = r_delim[{w_sel[2:0], 3'b000} +: BYTE_W];
        assign w_care = (DLEN_W'(k) < w_dlen);

        dss_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_byte_in (w_in),
            .i_want    (w_want),
            .i_care    (w_care),
            .o_byte    (w_byte[k]),
            .o_hit     (w_hit[k])
        );
    end

    always_comb begin
        w_pos_inc   = (r_pos >= CNT_MAX) ? CNT_MAX : r_pos + CNT_W'(1);
        w_bsm_inc   = (r_bsm == '1) ? r_bsm : r_bsm + BSM_W'(1);
        w_parts_inc = (r_parts >= CNT_MAX) ? CNT_MAX : r_parts + CNT_W'(1);
        w_parts_ok  = ((CMP_W'(r_parts) + CMP_W'(1)) < CMP_W'(w_lim));
        w_match     = i_has_byte && (w_dlen != '0) && (w_bsm_inc >= w_dlen)
                      && w_parts_ok && (&w_hit);

        w_p1     = {1'b0, r_pos} + (CNT_W+1)'(1);
        w_mstart = (w_p1 >= (CNT_W+1)'(w_dlen)) ? w_p1 - (CNT_W+1)'(w_dlen) : '0;
        w_mlen   = (w_mstart > {1'b0, r_cps}) ? w_mstart - {1'b0, r_cps} : '0;

        w_pos_a   = i_has_byte ? w_pos_inc : r_pos;
        w_cps_a   = w_match ? w_pos_inc : r_cps;
        w_parts_a = w_match ? w_parts_inc : r_parts;
        w_flen    = (w_pos_a > w_cps_a) ? w_pos_a - w_cps_a : '0;

        w_match_res.part_index      = PART_W'(r_parts);
        w_match_res.part_start      = PART_W'(r_cps);
        w_match_res.part_length     = PART_W'(w_mlen);
        w_match_res.last_part       = 1'b0;
        w_match_res.empty_delimiter = 1'b0;

        if (w_dlen == '0) begin
            w_final_res.part_index      = '0;
            w_final_res.part_start      = '0;
            w_final_res.part_length     = '0;
            w_final_res.empty_delimiter = 1'b1;
        end else begin
            w_final_res.part_index      = PART_W'(w_parts_a);
            w_final_res.part_start      = PART_W'(w_cps_a);
            w_final_res.part_length     = PART_W'(w_flen);
            w_final_res.empty_delimiter = 1'b0;
        end
        w_final_res.last_part = 1'b1;

        w_data0      = w_match ? w_match_res : w_final_res;
        w_push.push0 = w_accept && (w_match || i_last_byte);
        w_push.push1 = w_accept && w_match && i_last_byte;

        if (i_last_byte) begin
            n_pos   = '0;
            n_cps   = '0;
            n_bsm   = '0;
            n_parts = '0;
        end else begin
            n_pos   = w_pos_a;
            n_cps   = w_cps_a;
            n_bsm   = w_match ? '0 : (i_has_byte ? w_bsm_inc : r_bsm);
            n_parts = w_parts_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cps   <= '0;
            r_bsm   <= '0;
            r_parts <= '0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_cps   <= n_cps;
            r_bsm   <= n_bsm;
            r_parts <= n_parts;
        end
    end

    dss_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data0 (w_data0),
        .i_data1 (w_final_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_out),
        .o_room  (w_room)
    );

    assign o_part_index      = w_out.part_index;
    assign o_part_start      = w_out.part_start;
    assign o_part_length     = w_out.part_length;
    assign o_last_part       = w_out.last_part;
    assign o_empty_delimiter = w_out.empty_delimiter;

endmodule
